FILE: rtl/swpu_pkg.sv
// Shared types and codes for the stack with pop undo.
package swpu_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int FILL_W         = 7;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_UNDO = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOSAVE = 2'd3
    } t_status;

    // Shift controls for one chain of cells.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

FILE: rtl/swpu_if.sv
// Valid/ready channel interfaces for commands and results.
interface swpu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface swpu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic        top_valid;
    logic [31:0] top_value;
    logic [6:0]  main_fill;
    logic [6:0]  undo_fill;

    modport source (output valid, output status, output popped_value, output top_valid,
                    output top_value, output main_fill, output undo_fill, input ready);
    modport sink   (input valid, input status, input popped_value, input top_valid,
                    input top_value, input main_fill, input undo_fill, output ready);
endinterface

FILE: rtl/swpu_cell.sv
// One stack cell: holds an entry and shifts with its neighbors.
module swpu_cell #(
    parameter int DATA_WIDTH = swpu_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  swpu_pkg::t_shift      i_ctl,
    input  logic [DATA_WIDTH-1:0] i_from_up,
    input  logic [DATA_WIDTH-1:0] i_from_down,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        priority if (i_ctl.push) begin
            n_data = i_from_up;
        end else if (i_ctl.pop) begin
            n_data = i_from_down;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/swpu_chain.sv
// Row of cells forming one LIFO, top at cell zero, with its fill count.
module swpu_chain #(
    parameter int DEPTH      = swpu_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = swpu_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swpu_pkg::t_shift      i_ctl,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic [DATA_WIDTH-1:0] o_top,
    output logic [CW-1:0]         o_count
);

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_up   [DEPTH];
    logic [DATA_WIDTH-1:0] w_down [DEPTH];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_up[k] = i_data;
        end else begin : g_body
            assign w_up[k] = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign w_down[k] = '0;
        end else begin : g_link
            assign w_down[k] = w_data[k+1];
        end
        swpu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up[k]),
            .i_from_down (w_down[k]),
            .o_data      (w_data[k])
        );
    end

    always_comb begin
        priority if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = w_data[0];
    assign o_count = r_count;

endmodule

FILE: rtl/stack_with_pop_undo.sv
// Top level: command decode, two cell chains and the result register.
// A result is valid in the cycle after its command item is accepted.
// Throughput: one item per cycle while the output takes every result; each chain shifts all its cells at once.
// A new item is taken while the result register is empty or being drained.
// Reset clears both fill counts and the result valid; cell contents are not reset.
module stack_with_pop_undo #(
    parameter int DEPTH      = swpu_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = swpu_pkg::DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    swpu_in_if.sink         i_in,
    swpu_out_if.source      o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = swpu_pkg::FIELD_W;
    localparam int LW = swpu_pkg::FILL_W;

    swpu_pkg::t_shift      c_main;
    swpu_pkg::t_shift      c_undo;
    logic [DATA_WIDTH-1:0] main_in;
    logic [DATA_WIDTH-1:0] main_top;
    logic [DATA_WIDTH-1:0] undo_top;
    logic [CW-1:0]         main_cnt;
    logic [CW-1:0]         undo_cnt;
    logic [CW-1:0]         main_cnt_nxt;
    logic [CW-1:0]         undo_cnt_nxt;
    logic                  accept;
    logic                  main_full;
    logic                  main_empty;
    logic                  undo_full;
    logic                  undo_empty;
    swpu_pkg::t_cmd        cmd;
    swpu_pkg::t_status     status;
    logic                  popped;
    logic [DATA_WIDTH+FW-1:0] val_in_ext;
    logic [DATA_WIDTH+FW-1:0] top_ext;
    logic [CW+LW-1:0]      main_fill_ext;
    logic [CW+LW-1:0]      undo_fill_ext;

    logic                  r_valid;
    logic [1:0]            r_status;
    logic [FW-1:0]         r_popped;
    logic [LW-1:0]         r_main_fill;
    logic [LW-1:0]         r_undo_fill;

    assign accept     = i_in.valid && i_in.ready;
    assign cmd        = swpu_pkg::t_cmd'(i_in.cmd);
    assign main_full  = (main_cnt == CW'(DEPTH));
    assign main_empty = (main_cnt == '0);
    assign undo_full  = (undo_cnt == CW'(DEPTH));
    assign undo_empty = (undo_cnt == '0);

    // Keep the low bits of the sign-extended input value.
    assign val_in_ext = {{DATA_WIDTH{i_in.value[FW-1]}}, i_in.value};

    always_comb begin
        status = swpu_pkg::ST_OK;
        popped = 1'b0;
        c_main = '0;
        c_undo = '0;
        unique case (cmd)
            swpu_pkg::CMD_PUSH: begin
                if (main_full) begin
                    status = swpu_pkg::ST_FULL;
                end else begin
                    c_main.push = 1'b1;
                end
            end
            swpu_pkg::CMD_POP: begin
                if (main_empty) begin
                    status = swpu_pkg::ST_EMPTY;
                end else begin
                    c_main.pop = 1'b1;
                    popped     = 1'b1;
                    if (undo_full) begin
                        status = swpu_pkg::ST_NOSAVE;
                    end else begin
                        c_undo.push = 1'b1;
                    end
                end
            end
            swpu_pkg::CMD_UNDO: begin
                if (undo_empty) begin
                    status = swpu_pkg::ST_EMPTY;
                end else if (main_full) begin
                    status = swpu_pkg::ST_FULL;
                end else begin
                    c_undo.pop  = 1'b1;
                    c_main.push = 1'b1;
                end
            end
            swpu_pkg::CMD_NOP: begin
                status = swpu_pkg::ST_OK;
            end
            default: begin
                status = swpu_pkg::ST_OK;
            end
        endcase
        // Hold everything unless the item is taken.
        if (!accept) begin
            c_main = '0;
            c_undo = '0;
        end
    end

    assign main_in = (cmd == swpu_pkg::CMD_UNDO) ? undo_top : val_in_ext[DATA_WIDTH-1:0];

    always_comb begin
        priority if (c_main.push) begin
            main_cnt_nxt = main_cnt + CW'(1);
        end else if (c_main.pop) begin
            main_cnt_nxt = main_cnt - CW'(1);
        end else begin
            main_cnt_nxt = main_cnt;
        end
        priority if (c_undo.push) begin
            undo_cnt_nxt = undo_cnt + CW'(1);
        end else if (c_undo.pop) begin
            undo_cnt_nxt = undo_cnt - CW'(1);
        end else begin
            undo_cnt_nxt = undo_cnt;
        end
    end

    assign top_ext       = {{FW{main_top[DATA_WIDTH-1]}}, main_top};
    assign main_fill_ext = {{LW{1'b0}}, main_cnt_nxt};
    assign undo_fill_ext = {{LW{1'b0}}, undo_cnt_nxt};

    swpu_chain #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_main (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (c_main),
        .i_data   (main_in),
        .o_top    (main_top),
        .o_count  (main_cnt)
    );

    swpu_chain #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_undo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (c_undo),
        .i_data   (main_top),
        .o_top    (undo_top),
        .o_count  (undo_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_popped    <= popped ? top_ext[FW-1:0] : '0;
            r_main_fill <= main_fill_ext[LW-1:0];
            r_undo_fill <= undo_fill_ext[LW-1:0];
        end
    end

    assign i_in.ready         = !r_valid || o_out.ready;
    assign o_out.valid        = r_valid;
    assign o_out.status       = r_status;
    assign o_out.popped_value = r_popped;
    // The chains only move when an item is taken, so they match the held result.
    assign o_out.top_valid    = !main_empty;
    assign o_out.top_value    = main_empty ? '0 : top_ext[FW-1:0];
    assign o_out.main_fill    = r_main_fill;
    assign o_out.undo_fill    = r_undo_fill;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (main_cnt <= CW'(DEPTH)) && (undo_cnt <= CW'(DEPTH)))
        else $error("stack count beyond depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted item left no result");

    a_undo_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == swpu_pkg::CMD_UNDO && status == swpu_pkg::ST_OK)
        |=> (main_cnt == $past(main_cnt) + CW'(1)) && (undo_cnt == $past(undo_cnt) - CW'(1)))
        else $error("undo did not move one entry");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (status == swpu_pkg::ST_EMPTY || status == swpu_pkg::ST_FULL))
        |=> $stable(main_cnt) && $stable(undo_cnt))
        else $error("refused command changed a count");

endmodule
